@@ sv/dvrt_pkg.sv @@
// Shared types and constants for the distance-vector route table.
// Used by dvrt_cmp, the top level and the checker. No dependencies.
package dvrt_pkg;

	// most dump beats listed for one request
	localparam int MAX_RESULTS = 32;

	// unreachable metric
	localparam logic [4:0] METRIC_INF = 5'd16;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_INSERT  = 3'd1,
		ACT_DELETE  = 3'd2,
		ACT_REPLACE = 3'd3,
		ACT_FULL    = 3'd4,
		ACT_DUMP    = 3'd5,
		ACT_EMPTY   = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DUMP_RD,
		ST_DUMP_LD,
		ST_OUT_WAIT
	} state_t;

	// one table slot as held in the RAM
	typedef struct packed {
		logic [15:0] family;
		logic [15:0] tag;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [31:0] next_hop;
		logic [4:0]  metric;
	} route_entry_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic key_eq;
		logic hop_eq;
		logic met_lt;
	} cmp_res_t;

endpackage

@@ sv/dvrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/dvrt_cmp.sv @@
// Shared compare unit: key match, next-hop match and metric order.
// Depends on dvrt_pkg.
module dvrt_cmp (
	input  dvrt_pkg::route_entry_t entry,
	input  logic [31:0]            key_addr,
	input  logic [31:0]            key_mask,
	input  logic [31:0]            hop,
	input  logic [4:0]             metric,
	output dvrt_pkg::cmp_res_t     res
);

	always_comb begin
		res.key_eq = (entry.addr == key_addr) && (entry.mask == key_mask);
		res.hop_eq = (entry.next_hop == hop);
		res.met_lt = (metric < entry.metric);
	end

endmodule

@@ sv/distance_vector_route_table.sv @@
// Distance-vector route table: update and dump sequencer around one slot RAM.
// Update: the scan reads the filled slots (count = filled slots) from slot 0,
// one read per cycle through the slot RAM port, then decides and writes back.
// Dump: each beat passes DUMP_RD, DUMP_LD, OUT_WAIT; one beat for an empty table.
// One item at a time; reset clears the fill count and control state, not slot data.
module distance_vector_route_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] address_family,
	input  logic [15:0] route_tag,
	input  logic [31:0] route_addr,
	input  logic [31:0] route_mask,
	input  logic [31:0] next_hop,
	input  logic [4:0]  metric,
	input  logic [7:0]  arrival_iface,
	input  logic [31:0] peer_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [15:0] out_family,
	output logic [15:0] out_tag,
	output logic [31:0] out_addr,
	output logic [31:0] out_mask,
	output logic [31:0] out_next_hop,
	output logic [4:0]  out_metric,
	output logic [7:0]  out_iface,
	output logic        last
);

	localparam int IDX_W    = $clog2(TABLE_DEPTH);
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int LIST_MAX = (TABLE_DEPTH < dvrt_pkg::MAX_RESULTS) ?
		TABLE_DEPTH : dvrt_pkg::MAX_RESULTS;
	localparam int ENT_W    = $bits(dvrt_pkg::route_entry_t);

	// Slots are never freed and inserts take the lowest free slot, so the
	// filled slots are always 0 .. count-1: the fill count stands in for
	// per-slot valid bits and the first free slot is the count itself.

	dvrt_pkg::state_t state_q, state_d;

	// latched input beat
	logic        func_q;
	logic [15:0] fam_q;
	logic [15:0] tag_q;
	logic [31:0] addr_q;
	logic [31:0] mask_q;
	logic [31:0] nh_q;
	logic [4:0]  met_q;
	logic [7:0]  ifc_q;
	logic [31:0] peer_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_idx_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	dvrt_pkg::route_entry_t hit_entry_q;

	// result register
	logic [2:0]  action_q;
	logic [15:0] fam_out_q;
	logic [15:0] tag_out_q;
	logic [31:0] addr_out_q;
	logic [31:0] mask_out_q;
	logic [31:0] nh_out_q;
	logic [4:0]  met_out_q;
	logic [7:0]  ifc_out_q;
	logic        last_q;

	// control
	logic accept;
	logic scan_issue;
	logic scan_done;
	logic ram_re;
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	dvrt_pkg::route_entry_t ram_wdata;
	dvrt_pkg::route_entry_t ram_rdata;
	logic [ENT_W-1:0] ram_rdata_raw;
	logic load_empty;
	logic load_decide;
	logic load_dump;
	logic dec_insert;
	dvrt_pkg::action_t dec_act;
	logic [7:0]  dec_ifc;
	logic [4:0]  clamp_met;
	logic [CNT_W-1:0] list_n;

	dvrt_pkg::route_entry_t cmp_entry;
	logic [31:0]            cmp_hop;
	dvrt_pkg::cmp_res_t     cmp_res;

	// slot store
	dvrt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = dvrt_pkg::route_entry_t'(ram_rdata_raw);

	// one compare unit serves scan, decide and dump
	assign cmp_entry = (state_q == dvrt_pkg::ST_DECIDE) ? hit_entry_q : ram_rdata;
	assign cmp_hop   = func_q ? peer_q : nh_q;

	dvrt_cmp u_cmp (
		.entry    (cmp_entry),
		.key_addr (addr_q),
		.key_mask (mask_q),
		.hop      (cmp_hop),
		.metric   (met_q),
		.res      (cmp_res)
	);

	assign clamp_met = (met_q >= dvrt_pkg::METRIC_INF) ? dvrt_pkg::METRIC_INF : met_q;
	assign list_n    = (count_q > CNT_W'(LIST_MAX)) ? CNT_W'(LIST_MAX) : count_q;
	assign scan_done = (scan_idx_q == count_q) && !cmp_vld_s1;

	// update decision from the scan outcome
	always_comb begin
		dec_act    = dvrt_pkg::ACT_NONE;
		dec_ifc    = 8'd0;
		dec_insert = 1'b0;
		ram_waddr  = hit_idx_q;
		if (hit_q) begin
			if (cmp_res.hop_eq) begin
				if (met_q >= dvrt_pkg::METRIC_INF) begin
					dec_act = dvrt_pkg::ACT_DELETE;
				end
			end else if (cmp_res.met_lt) begin
				dec_act = dvrt_pkg::ACT_REPLACE;
				dec_ifc = ifc_q;
			end
		end else if (met_q < dvrt_pkg::METRIC_INF) begin
			if (count_q < CNT_W'(TABLE_DEPTH)) begin
				dec_act    = dvrt_pkg::ACT_INSERT;
				dec_ifc    = ifc_q;
				dec_insert = 1'b1;
				ram_waddr  = count_q[IDX_W-1:0];
			end else begin
				dec_act = dvrt_pkg::ACT_FULL;
			end
		end
	end

	always_comb begin
		ram_wdata.family   = fam_q;
		ram_wdata.tag      = tag_q;
		ram_wdata.addr     = addr_q;
		ram_wdata.mask     = mask_q;
		ram_wdata.next_hop = nh_q;
		ram_wdata.metric   = clamp_met;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dvrt_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!func) begin
						state_d = dvrt_pkg::ST_SCAN;
					end else if (count_q == '0) begin
						state_d = dvrt_pkg::ST_OUT_WAIT;
					end else begin
						state_d = dvrt_pkg::ST_DUMP_RD;
					end
				end
			end
			dvrt_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = dvrt_pkg::ST_DECIDE;
				end
			end
			dvrt_pkg::ST_DECIDE:  state_d = dvrt_pkg::ST_OUT_WAIT;
			dvrt_pkg::ST_DUMP_RD: state_d = dvrt_pkg::ST_DUMP_LD;
			dvrt_pkg::ST_DUMP_LD: state_d = dvrt_pkg::ST_OUT_WAIT;
			dvrt_pkg::ST_OUT_WAIT: begin
				if (!out_stall) begin
					state_d = last_q ? dvrt_pkg::ST_IDLE : dvrt_pkg::ST_DUMP_RD;
				end
			end
			default: state_d = dvrt_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		accept      = 1'b0;
		scan_issue  = 1'b0;
		ram_re      = 1'b0;
		ram_we      = 1'b0;
		load_empty  = 1'b0;
		load_decide = 1'b0;
		load_dump   = 1'b0;
		unique case (state_q)
			dvrt_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				accept     = in_valid;
				load_empty = in_valid && func && (count_q == '0);
			end
			dvrt_pkg::ST_SCAN: begin
				scan_issue = (scan_idx_q < count_q);
				ram_re     = scan_issue;
			end
			dvrt_pkg::ST_DECIDE: begin
				load_decide = 1'b1;
				ram_we      = (dec_act == dvrt_pkg::ACT_DELETE) ||
					(dec_act == dvrt_pkg::ACT_REPLACE) ||
					(dec_act == dvrt_pkg::ACT_INSERT) ||
					(hit_q && cmp_res.hop_eq);
			end
			dvrt_pkg::ST_DUMP_RD: ram_re = 1'b1;
			dvrt_pkg::ST_DUMP_LD: load_dump = 1'b1;
			dvrt_pkg::ST_OUT_WAIT: out_valid = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dvrt_pkg::ST_IDLE;
			count_q    <= '0;
			scan_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				scan_idx_q <= '0;
				cmp_vld_s1 <= 1'b0;
				hit_q      <= 1'b0;
			end
			if (state_q == dvrt_pkg::ST_SCAN) begin
				cmp_vld_s1 <= scan_issue;
				if (scan_issue) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
				if (cmp_vld_s1 && cmp_res.key_eq && !hit_q) begin
					hit_q <= 1'b1;
				end
			end
			if (load_decide && dec_insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (load_dump) begin
				scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			fam_q  <= address_family;
			tag_q  <= route_tag;
			addr_q <= route_addr;
			mask_q <= route_mask;
			nh_q   <= next_hop;
			met_q  <= metric;
			ifc_q  <= arrival_iface;
			peer_q <= peer_addr;
		end
		cmp_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if ((state_q == dvrt_pkg::ST_SCAN) && cmp_vld_s1 && cmp_res.key_eq && !hit_q) begin
			hit_idx_q   <= cmp_idx_s1;
			hit_entry_q <= ram_rdata;
		end
		if (load_empty) begin
			action_q   <= dvrt_pkg::ACT_EMPTY;
			fam_out_q  <= 16'd0;
			tag_out_q  <= 16'd0;
			addr_out_q <= 32'd0;
			mask_out_q <= 32'd0;
			nh_out_q   <= 32'd0;
			met_out_q  <= 5'd0;
			ifc_out_q  <= 8'd0;
			last_q     <= 1'b1;
		end else if (load_decide) begin
			action_q   <= dec_act;
			fam_out_q  <= fam_q;
			tag_out_q  <= tag_q;
			addr_out_q <= addr_q;
			mask_out_q <= mask_q;
			nh_out_q   <= nh_q;
			met_out_q  <= clamp_met;
			ifc_out_q  <= dec_ifc;
			last_q     <= 1'b1;
		end else if (load_dump) begin
			// poison reverse toward the requesting peer
			action_q   <= dvrt_pkg::ACT_DUMP;
			fam_out_q  <= ram_rdata.family;
			tag_out_q  <= ram_rdata.tag;
			addr_out_q <= ram_rdata.addr;
			mask_out_q <= ram_rdata.mask;
			nh_out_q   <= ram_rdata.next_hop;
			met_out_q  <= cmp_res.hop_eq ? dvrt_pkg::METRIC_INF : ram_rdata.metric;
			ifc_out_q  <= 8'd0;
			last_q     <= ((scan_idx_q + CNT_W'(1)) == list_n);
		end
	end

	assign action       = action_q;
	assign out_family   = fam_out_q;
	assign out_tag      = tag_out_q;
	assign out_addr     = addr_out_q;
	assign out_mask     = mask_out_q;
	assign out_next_hop = nh_out_q;
	assign out_metric   = met_out_q;
	assign out_iface    = ifc_out_q;
	assign last         = last_q;

endmodule

@@ sv/dvrt_chk.sv @@
// Port-level checks for distance_vector_route_table, bound to the top level.
// Depends on dvrt_pkg.
module dvrt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  action,
	input logic [4:0]  out_metric,
	input logic        last
);

	// one item at a time: busy straight after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input beat taken while previous item still in progress");

	// no input beat while a result is pending
	a_stall_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result beat pending");

	// update and empty-dump results are single beats
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action != dvrt_pkg::ACT_DUMP) |-> last)
		else $error("non-dump result without last");

	// reported metric never exceeds unreachable
	a_metric_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_metric <= dvrt_pkg::METRIC_INF))
		else $error("reported metric above unreachable");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action) && $stable(last))
		else $error("stalled result beat changed");

endmodule

bind distance_vector_route_table dvrt_chk u_dvrt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.action     (action),
	.out_metric (out_metric),
	.last       (last)
);

@@ test/distance_vector_route_table_tb.sv @@
// Self-checking bench for distance_vector_route_table: directed rows, then random bursts.
// Results are checked against an in-bench predictor of the route table.
// Needs dvrt_pkg and the block's RTL only.
module distance_vector_route_table_tb;

	localparam int TABLE_DEPTH      = 32;
	localparam int RESET_CYCLES     = 9;
	localparam int RANDOM_ITEMS     = 220;
	localparam int HOLD_AFTER_ITEMS = 60;   // random beat that triggers the long hold-off
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES      = 2 * TABLE_DEPTH + 16;
	localparam int KEY_POOL_SIZE    = 64;
	localparam longint TIMEOUT      = 64'd12_000_000;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_DUMP   = 1'b1;

	// fixed keys and neighbours for the directed rows
	localparam logic [31:0] NET_A   = 32'h0A01_0000;
	localparam logic [31:0] MASK_16 = 32'hFFFF_0000;
	localparam logic [31:0] MASK_24 = 32'hFFFF_FF00;
	localparam logic [31:0] HOP_A   = 32'hC0A8_0001;
	localparam logic [31:0] HOP_B   = 32'hC0A8_0002;
	localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        func;
		logic [15:0] fam;
		logic [15:0] tag;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [31:0] nh;
		logic [4:0]  met;
		logic [7:0]  ifc;
		logic [31:0] peer;
	} route_item_t;

	typedef struct packed {
		dvrt_pkg::action_t act;
		logic [15:0] fam;
		logic [15:0] tag;
		logic [31:0] addr;
		logic [31:0] mask;
		logic [31:0] nh;
		logic [4:0]  met;
		logic [7:0]  ifc;
		logic        last;
	} route_beat_t;

	typedef struct packed {
		route_item_t item;
		logic        typed;  // want holds a hand-written result
		route_beat_t want;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] mask;
	} route_key_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [15:0] address_family;
	logic [15:0] route_tag;
	logic [31:0] route_addr;
	logic [31:0] route_mask;
	logic [31:0] next_hop;
	logic [4:0]  metric;
	logic [7:0]  arrival_iface;
	logic [31:0] peer_addr;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  action;
	logic [15:0] out_family;
	logic [15:0] out_tag;
	logic [31:0] out_addr;
	logic [31:0] out_mask;
	logic [31:0] out_next_hop;
	logic [4:0]  out_metric;
	logic [7:0]  out_iface;
	logic        last;

	// predictor state: our own copy of the route table
	dvrt_pkg::route_entry_t route_ram [TABLE_DEPTH];
	bit           route_live [TABLE_DEPTH];

	route_beat_t  route_beats_due[$];   // results still to come, oldest first
	route_beat_t  fresh_beats[$];       // results of the item just predicted
	stim_row_t    stim_rows[$];
	route_key_t   known_keys[$];        // keys offered so far, reused by the random part
	logic [31:0]  neighbours [4];
	route_beat_t  no_beat;
	int           beat_errors;
	bit           hold_off_due;

	distance_vector_route_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.address_family(address_family),
		.route_tag(route_tag),
		.route_addr(route_addr),
		.route_mask(route_mask),
		.next_hop(next_hop),
		.metric(metric),
		.arrival_iface(arrival_iface),
		.peer_addr(peer_addr),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.out_family(out_family),
		.out_tag(out_tag),
		.out_addr(out_addr),
		.out_mask(out_mask),
		.out_next_hop(out_next_hop),
		.out_metric(out_metric),
		.out_iface(out_iface),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop, well beyond the slowest legal run.
	initial begin
		#(TIMEOUT);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic route_beat_t make_beat(input dvrt_pkg::action_t act,
			input logic [15:0] fam, input logic [15:0] tag, input logic [31:0] addr,
			input logic [31:0] mask, input logic [31:0] nh, input logic [4:0] met,
			input logic [7:0] ifc, input logic lst);
		route_beat_t b;
		b.act  = act;
		b.fam  = fam;
		b.tag  = tag;
		b.addr = addr;
		b.mask = mask;
		b.nh   = nh;
		b.met  = met;
		b.ifc  = ifc;
		b.last = lst;
		return b;
	endfunction

	function automatic route_item_t upd(input logic [15:0] fam, input logic [15:0] tag,
			input logic [31:0] addr, input logic [31:0] mask, input logic [31:0] nh,
			input logic [4:0] met, input logic [7:0] ifc);
		route_item_t it;
		it.func = FUNC_UPDATE;
		it.fam  = fam;
		it.tag  = tag;
		it.addr = addr;
		it.mask = mask;
		it.nh   = nh;
		it.met  = met;
		it.ifc  = ifc;
		it.peer = 32'd0;
		return it;
	endfunction

	function automatic route_item_t dump_for(input logic [31:0] peer);
		route_item_t it;
		it      = '0;
		it.func = FUNC_DUMP;
		it.peer = peer;
		return it;
	endfunction

	function automatic void add_row(input route_item_t it);
		stim_row_t r;
		r.item    = it;
		r.typed   = 1'b0;
		r.want    = no_beat;
		stim_rows = {stim_rows, r};
	endfunction

	function automatic void add_typed_row(input route_item_t it, input route_beat_t want);
		stim_row_t r;
		r.item    = it;
		r.typed   = 1'b1;
		r.want    = want;
		stim_rows = {stim_rows, r};
	endfunction

	// Overwrite a slot with the advertised route and the clamped metric.
	function automatic void keep_route(input int s, input route_item_t it,
			input logic [4:0] met);
		route_live[s]         = 1'b1;
		route_ram[s].family   = it.fam;
		route_ram[s].tag      = it.tag;
		route_ram[s].addr     = it.addr;
		route_ram[s].mask     = it.mask;
		route_ram[s].next_hop = it.nh;
		route_ram[s].metric   = met;
	endfunction

	// Predictor: merges one accepted item into the table copy and leaves the
	// results it causes in fresh_beats.
	function automatic void apply_route_item(input route_item_t it);
		int          s;
		int          n;
		int          hit;
		int          spare;
		logic [4:0]  capped;
		logic [4:0]  shown;
		dvrt_pkg::action_t act;
		logic [7:0]  ifc;
		fresh_beats.delete();
		if (it.func == FUNC_DUMP) begin
			n = 0;
			for (s = 0; s < TABLE_DEPTH && n < dvrt_pkg::MAX_RESULTS; s++) begin
				if (route_live[s]) begin
					// poison reverse toward the asking neighbour
					shown = (route_ram[s].next_hop == it.peer) ? dvrt_pkg::METRIC_INF
						: route_ram[s].metric;
					fresh_beats = {fresh_beats, make_beat(dvrt_pkg::ACT_DUMP,
						route_ram[s].family, route_ram[s].tag, route_ram[s].addr,
						route_ram[s].mask, route_ram[s].next_hop, shown, 8'd0, 1'b0)};
					n++;
				end
			end
			if (n == 0)
				fresh_beats = {fresh_beats, make_beat(dvrt_pkg::ACT_EMPTY, '0, '0, '0,
					'0, '0, '0, '0, 1'b1)};
			else
				fresh_beats[n - 1].last = 1'b1;
			return;
		end
		capped = (it.met >= dvrt_pkg::METRIC_INF) ? dvrt_pkg::METRIC_INF : it.met;
		act    = dvrt_pkg::ACT_NONE;
		ifc    = 8'd0;
		hit    = -1;
		spare  = -1;
		for (s = 0; s < TABLE_DEPTH; s++) begin
			if (route_live[s]) begin
				if (hit < 0 && route_ram[s].addr == it.addr && route_ram[s].mask == it.mask)
					hit = s;
			end else if (spare < 0) begin
				spare = s;
			end
		end
		if (hit >= 0) begin
			if (route_ram[hit].next_hop == it.nh) begin
				// same neighbour: always take its word, unreachable means withdraw
				keep_route(hit, it, capped);
				if (it.met >= dvrt_pkg::METRIC_INF)
					act = dvrt_pkg::ACT_DELETE;
			end else if (it.met < route_ram[hit].metric) begin
				keep_route(hit, it, capped);
				act = dvrt_pkg::ACT_REPLACE;
				ifc = it.ifc;
			end
		end else if (it.met < dvrt_pkg::METRIC_INF) begin
			if (spare >= 0) begin
				keep_route(spare, it, capped);
				act = dvrt_pkg::ACT_INSERT;
				ifc = it.ifc;
			end else begin
				act = dvrt_pkg::ACT_FULL;
			end
		end
		fresh_beats = {fresh_beats, make_beat(act, it.fam, it.tag, it.addr, it.mask,
			it.nh, capped, ifc, 1'b1)};
	endfunction

	// Directed rows: empty dump, insert, refresh, keep, replace and withdraw on one key,
	// field extremes, a key differing in mask only, and poison reverse on several peers.
	function automatic void load_directed();
		route_item_t it;
		it = dump_for(32'd0);
		add_typed_row(it, make_beat(dvrt_pkg::ACT_EMPTY, '0, '0, '0, '0, '0, '0, '0,
			1'b1));
		it = upd(16'd2, 16'd0, NET_A, MASK_16, HOP_A, 5'd31, 8'd1);
		add_typed_row(it, make_beat(dvrt_pkg::ACT_NONE, 16'd2, 16'd0, NET_A, MASK_16,
			HOP_A, dvrt_pkg::METRIC_INF, 8'd0, 1'b1));
		it = upd(16'd2, 16'd0, NET_A, MASK_16, HOP_A, 5'd16, 8'd1);
		add_typed_row(it, make_beat(dvrt_pkg::ACT_NONE, 16'd2, 16'd0, NET_A, MASK_16,
			HOP_A, dvrt_pkg::METRIC_INF, 8'd0, 1'b1));
		add_row(upd(16'd2, 16'h0001, NET_A, MASK_16, HOP_A, 5'd0, 8'd3));   // insert
		add_row(upd(16'd2, 16'h0002, NET_A, MASK_16, HOP_A, 5'd5, 8'd3));   // refresh
		add_row(upd(16'd2, 16'h0003, NET_A, MASK_16, HOP_B, 5'd5, 8'd4));   // equal: kept
		add_row(upd(16'd2, 16'h0004, NET_A, MASK_16, HOP_B, 5'd2, 8'd4));   // better: replace
		add_row(upd(16'd2, 16'h0005, NET_A, MASK_16, HOP_B, 5'd16, 8'd4));  // withdraw
		add_row(upd(16'd2, 16'h0006, NET_A, MASK_16, HOP_A, 5'd15, 8'd5));  // beats 16
		add_row(upd(16'd2, 16'h0007, NET_A, MASK_16, HOP_A, 5'd31, 8'd5));  // withdraw again
		it = upd(16'hFFFF, 16'hFFFF, ALL_ONE, ALL_ONE, ALL_ONE, 5'd15, 8'hFF);
		it.peer = ALL_ONE;
		add_typed_row(it, make_beat(dvrt_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF, ALL_ONE,
			ALL_ONE, ALL_ONE, 5'd15, 8'hFF, 1'b1));
		add_row(upd(16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 5'd0, 8'd0));
		add_row(upd(16'd2, 16'h0008, NET_A, MASK_24, HOP_A, 5'd1, 8'd6));   // mask differs
		add_row(upd(16'd2, 16'h0009, NET_A | 32'h100, MASK_24, HOP_B, 5'd9, 8'd6));
		add_row(dump_for(HOP_A));
		add_row(dump_for(ALL_ONE));
		add_row(dump_for(32'd0));
		add_row(upd(16'h1234, 16'h5678, ALL_ONE, ALL_ONE, 32'd0, 5'd14, 8'd7)); // replace
		add_row(dump_for(32'h1234_5678));
	endfunction

	// One random item. Mostly updates on known keys and neighbours so that every
	// merge outcome keeps recurring; a share of fresh keys fills the table up,
	// a few dumps and a little pure noise on top.
	function automatic route_item_t random_route();
		route_item_t it;
		route_key_t  key;
		int          pick;
		int          s;
		it.func = FUNC_UPDATE;
		it.fam  = 16'($urandom);
		it.tag  = 16'($urandom);
		it.ifc  = 8'($urandom);
		it.peer = $urandom;
		it.addr = $urandom;
		it.mask = $urandom;
		it.nh   = $urandom;
		it.met  = 5'($urandom);
		pick    = $urandom_range(0, 99);
		if (pick < 10) begin
			it.func = FUNC_DUMP;
			if ($urandom_range(0, 9) < 7)
				it.peer = neighbours[$urandom_range(0, 3)];
			return it;
		end
		if (pick < 15)
			return it;
		if (known_keys.size() == 0 || pick < 40) begin
			key.mask = ALL_ONE << $urandom_range(0, 32);
			key.addr = $urandom;
			if ($urandom_range(0, 3) != 0)
				key.addr = key.addr & key.mask;
			if (known_keys.size() < KEY_POOL_SIZE)
				known_keys = {known_keys, key};
			else
				known_keys[$urandom_range(0, KEY_POOL_SIZE - 1)] = key;
		end else begin
			key = known_keys[$urandom_range(0, known_keys.size() - 1)];
		end
		it.addr = key.addr;
		it.mask = key.mask;
		it.nh   = neighbours[$urandom_range(0, 3)];
		// often come back from the neighbour that holds the route now
		if ($urandom_range(0, 1) == 0) begin
			for (s = 0; s < TABLE_DEPTH; s++) begin
				if (route_live[s] && route_ram[s].addr == key.addr &&
						route_ram[s].mask == key.mask)
					it.nh = route_ram[s].next_hop;
			end
		end
		it.met = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 15))
			: 5'($urandom_range(16, 31));
		return it;
	endfunction

	// Offer one beat at the falling edge and hold it until taken.
	task automatic send_item(input route_item_t it, input logic typed, input route_beat_t want);
		@(negedge clk);
		in_valid       <= 1'b1;
		func           <= it.func;
		address_family <= it.fam;
		route_tag      <= it.tag;
		route_addr     <= it.addr;
		route_mask     <= it.mask;
		next_hop       <= it.nh;
		metric         <= it.met;
		arrival_iface  <= it.ifc;
		peer_addr      <= it.peer;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		apply_route_item(it);
		if (typed)
			route_beats_due = {route_beats_due, want};
		else
			foreach (fresh_beats[k])
				route_beats_due = {route_beats_due, fresh_beats[k]};
	endtask

	task automatic idle_for(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Sender: reset, directed rows, random bursts, then drain and verdict.
	initial begin : sender
		int sent;
		int burst;
		int k;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		func           = FUNC_UPDATE;
		address_family = '0;
		route_tag      = '0;
		route_addr     = '0;
		route_mask     = '0;
		next_hop       = '0;
		metric         = '0;
		arrival_iface  = '0;
		peer_addr      = '0;
		beat_errors    = 0;
		hold_off_due   = 1'b0;
		no_beat        = '0;
		for (k = 0; k < TABLE_DEPTH; k++)
			route_live[k] = 1'b0;
		load_directed();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[r]) begin
			send_item(stim_rows[r].item, stim_rows[r].typed, stim_rows[r].want);
			idle_for($urandom_range(0, 2));
		end

		for (k = 0; k < 4; k++)
			neighbours[k] = $urandom;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				send_item(random_route(), 1'b0, no_beat);
				sent++;
				if (sent == HOLD_AFTER_ITEMS)
					hold_off_due = 1'b1;
			end
			// a third of the bursts run straight into the next one
			idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
		end
		idle_for(1);

		while (route_beats_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (beat_errors == 0 && route_beats_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: runs of no stall, random stall and alternate stall, plus one long
	// hold-off so the block backs up and stalls its input.
	initial begin : receiver
		int mode;
		int run;
		int k;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				for (k = 0; k < LONG_HOLD_CYCLES; k++) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			mode = $urandom_range(0, 2);
			run  = $urandom_range(8, 40);
			for (k = 0; k < run; k++) begin
				@(negedge clk);
				case (mode)
					0: begin
						out_stall <= 1'b0;
					end
					1: begin
						out_stall <= ($urandom_range(0, 2) == 0);
					end
					default: begin
						out_stall <= k[0];
					end
				endcase
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			beat_errors++;
		end
	endfunction

	// Result monitor: each taken beat against the oldest outstanding result.
	always @(posedge clk) begin : watch_results
		route_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (route_beats_due.size() == 0) begin
				$display("%0t: unexpected result beat, action %0h", $time, action);
				beat_errors++;
			end else begin
				want = route_beats_due.pop_front();
				check_field("action", want.act, action);
				check_field("out_family", want.fam, out_family);
				check_field("out_tag", want.tag, out_tag);
				check_field("out_addr", want.addr, out_addr);
				check_field("out_mask", want.mask, out_mask);
				check_field("out_next_hop", want.nh, out_next_hop);
				check_field("out_metric", want.met, out_metric);
				check_field("out_iface", want.ifc, out_iface);
				check_field("last", want.last, last);
			end
		end
	end

endmodule

@@ files.f @@
sv/dvrt_pkg.sv
sv/dvrt_ram.sv
sv/dvrt_cmp.sv
sv/distance_vector_route_table.sv
sv/dvrt_chk.sv
test/distance_vector_route_table_tb.sv
